### rtl/core/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the pitch track table: controller states,
// track field codes, register indexes and the command and status bundles.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [8:0]  ALPHA_ONE  = 9'd256;
  localparam logic [8:0]  ALPHA_RST  = 9'd128;
  localparam logic [15:0] WINDOW_RST = 16'd1280;
  localparam logic [15:0] STALE_RST  = 16'd300;
  localparam logic [15:0] MOD_JUMP   = 16'd24;
  localparam logic [15:0] UNIT_Q15   = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_PICK,
    ST_BLEND,
    ST_WGHT,
    ST_OUT
  } ptt_state_t;

  typedef enum logic [2:0] {
    FLD_PITCH,
    FLD_AMP,
    FLD_CEN,
    FLD_BW,
    FLD_HARM,
    FLD_COH,
    FLD_MOD
  } ptt_field_t;

  typedef enum logic [1:0] {
    REG_ALPHA,
    REG_WINDOW,
    REG_STALE
  } ptt_reg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic age;
    logic pick;
    logic blend;
    logic wght;
    logic emit;
  } ptt_cmd_t;

  typedef struct packed {
    logic last_slot;
    logic last_field;
    logic out_free;
  } ptt_sts_t;

  function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
    absdiff16 = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/core/ptt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer of the pitch track table: slot scan, age pass, slot choice,
// per-field smoothing, weighting and result hand-off.
// ----------------------------------------------------------------------------
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_stall,
  input  ptt_sts_t sts,
  output ptt_cmd_t cmd
);

  ptt_state_t state_r;
  ptt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_action ? ST_AGE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_slot) begin
          state_nxt = ST_PICK;
        end
      end
      ST_AGE: begin
        cmd.age = 1'b1;
        if (sts.last_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.blend = 1'b1;
        if (sts.last_field) begin
          state_nxt = ST_WGHT;
        end
      end
      ST_WGHT: begin
        cmd.wght  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_pick_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PICK |-> $past(state_r) == ST_SCAN)
    else $error("slot choice without a completed scan");

  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && sts.out_free |=> state_r == ST_IDLE)
    else $error("result hand-off did not return to idle");

endmodule

### rtl/core/ptt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_dp
// Datapath of the pitch track table: track store, nearest and stalest
// search, shared smoothing multiplier, harmonicity weighting and the
// result register.
// ----------------------------------------------------------------------------
module ptt_dp
  import ptt_pkg::*;
#(
  parameter int TRACK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ptt_cmd_t    cmd,
  output ptt_sts_t    sts,
  input  logic [8:0]  alpha,
  input  logic [15:0] window,
  input  logic [15:0] stale_limit,
  input  logic [31:0] in_timestamp_ms,
  input  logic [15:0] in_pitch,
  input  logic [15:0] in_amplitude,
  input  logic [15:0] in_centroid,
  input  logic [15:0] in_bandwidth,
  input  logic [15:0] in_harmonicity,
  input  logic [15:0] in_coherence,
  input  logic [7:0]  in_modulation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_track_id,
  output logic        out_is_new,
  output logic [15:0] out_smoothed_pitch,
  output logic [15:0] out_smoothed_amplitude,
  output logic [15:0] out_smoothed_centroid,
  output logic [15:0] out_smoothed_bandwidth,
  output logic [15:0] out_weighted_harmonicity,
  output logic [15:0] out_smoothed_coherence,
  output logic [7:0]  out_smoothed_modulation
);

  localparam int SLOT_W = $clog2(TRACK_SLOTS);
  localparam int CW     = (SLOT_W > 3) ? SLOT_W : 3;
  localparam logic [CW-1:0] CNT_LAST = CW'(TRACK_SLOTS - 1);
  localparam logic [CW-1:0] FLD_END  = CW'(FLD_MOD);

  // candidate
  logic [31:0] ts_r;
  logic [15:0] pitch_r, amp_r, cen_r, bw_r, harm_r, coh_r;
  logic [7:0]  mod_r;

  // track store
  logic        act_r   [TRACK_SLOTS];
  logic [7:0]  id_r    [TRACK_SLOTS];
  logic [15:0] tpitch_r[TRACK_SLOTS];
  logic [15:0] tamp_r  [TRACK_SLOTS];
  logic [15:0] tcen_r  [TRACK_SLOTS];
  logic [15:0] tbw_r   [TRACK_SLOTS];
  logic [15:0] tharm_r [TRACK_SLOTS];
  logic [15:0] tcoh_r  [TRACK_SLOTS];
  logic [7:0]  tmod_r  [TRACK_SLOTS];
  logic [31:0] tseen_r [TRACK_SLOTS];
  logic [7:0]  next_id_r;

  // search state
  logic [CW-1:0]     cnt_r;
  logic [SLOT_W-1:0] best_idx_r, free_idx_r, stale_idx_r, slot_r;
  logic [15:0]       best_d_r;
  logic              best_vld_r, free_vld_r, new_r;
  logic [31:0]       stale_ts_r;
  logic [32:0]       wh_prod_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_slot_r;
  logic [7:0]  out_id_r;
  logic        out_new_r;
  logic [15:0] out_pitch_r, out_amp_r, out_cen_r, out_bw_r, out_wh_r, out_coh_r;
  logic [7:0]  out_mod_r;

  logic [SLOT_W-1:0] idx;
  logic              rd_act;
  logic [15:0]       rd_pitch, rd_amp, rd_cen, rd_bw, rd_harm, rd_coh;
  logic [7:0]        rd_mod, rd_id;
  logic [31:0]       rd_seen;
  logic [15:0]       pitch_d;
  logic              retire;
  logic              match;
  logic [SLOT_W-1:0] pick_slot;
  logic [8:0]        a_sat;
  ptt_field_t        field;
  logic [15:0]       old_v, x_v, new_v, blended;
  logic signed [16:0] diff;
  logic signed [26:0] prod;
  logic signed [27:0] acc;
  logic              jump;
  logic [16:0]       coh_plus;
  logic [33:0]       wh_sum;
  logic [17:0]       wh_q;
  logic [CW-1:0]     slot_ext;

  assign idx      = (cmd.scan || cmd.age) ? cnt_r[SLOT_W-1:0] : slot_r;
  assign rd_act   = act_r[idx];
  assign rd_id    = id_r[idx];
  assign rd_pitch = tpitch_r[idx];
  assign rd_amp   = tamp_r[idx];
  assign rd_cen   = tcen_r[idx];
  assign rd_bw    = tbw_r[idx];
  assign rd_harm  = tharm_r[idx];
  assign rd_coh   = tcoh_r[idx];
  assign rd_mod   = tmod_r[idx];
  assign rd_seen  = tseen_r[idx];

  assign pitch_d = absdiff16(rd_pitch, pitch_r);
  assign retire  = rd_act && (ts_r > rd_seen) && ((ts_r - rd_seen) > {16'd0, stale_limit});

  assign match     = best_vld_r && (best_d_r < window);
  assign pick_slot = match ? best_idx_r : (free_vld_r ? free_idx_r : stale_idx_r);

  assign a_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign field = ptt_field_t'(cnt_r[2:0]);

  always_comb begin
    case (field)
      FLD_PITCH: begin old_v = rd_pitch;       x_v = pitch_r;       end
      FLD_AMP:   begin old_v = rd_amp;         x_v = amp_r;         end
      FLD_CEN:   begin old_v = rd_cen;         x_v = cen_r;         end
      FLD_BW:    begin old_v = rd_bw;          x_v = bw_r;          end
      FLD_HARM:  begin old_v = rd_harm;        x_v = harm_r;        end
      FLD_COH:   begin old_v = rd_coh;         x_v = coh_r;         end
      FLD_MOD:   begin old_v = {8'd0, rd_mod}; x_v = {8'd0, mod_r}; end
      default:   begin old_v = '0;             x_v = '0;            end
    endcase
  end

  // old*256 + a*(x - old) + 128
  assign diff    = $signed({1'b0, x_v}) - $signed({1'b0, old_v});
  assign prod    = $signed({1'b0, a_sat}) * diff;
  assign acc     = $signed({4'd0, old_v, 8'h80}) + $signed({prod[26], prod});
  assign blended = acc[23:8];
  assign jump    = (field == FLD_MOD) && (absdiff16(old_v, x_v) > MOD_JUMP);
  assign new_v   = (new_r || jump) ? x_v : blended;

  assign coh_plus = 17'(UNIT_Q15) + 17'(rd_coh);
  assign wh_sum   = {1'b0, wh_prod_r} + 34'(UNIT_Q15);
  assign wh_q     = wh_sum[33:16];
  assign slot_ext = CW'(slot_r);

  assign sts.last_slot  = (cnt_r == CNT_LAST);
  assign sts.last_field = (cnt_r == FLD_END);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      next_id_r <= '0;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        act_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.load || cmd.pick) begin
        cnt_r <= '0;
      end else if (cmd.scan || cmd.age || cmd.blend) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.age && retire) begin
        act_r[idx] <= 1'b0;
      end
      if (cmd.pick && !match) begin
        act_r[pick_slot] <= 1'b1;
        next_id_r        <= next_id_r + 8'd1;
      end
    end
  end

  // candidate capture, search and table payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r       <= in_timestamp_ms;
      pitch_r    <= in_pitch;
      amp_r      <= in_amplitude;
      cen_r      <= in_centroid;
      bw_r       <= in_bandwidth;
      harm_r     <= in_harmonicity;
      coh_r      <= in_coherence;
      mod_r      <= in_modulation;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
    end
    if (cmd.scan) begin
      if (rd_act && (!best_vld_r || pitch_d < best_d_r)) begin
        best_vld_r <= 1'b1;
        best_d_r   <= pitch_d;
        best_idx_r <= idx;
      end
      if (!rd_act && !free_vld_r) begin
        free_vld_r <= 1'b1;
        free_idx_r <= idx;
      end
      if (cnt_r == '0 || rd_seen < stale_ts_r) begin
        stale_ts_r  <= rd_seen;
        stale_idx_r <= idx;
      end
    end
    if (cmd.pick) begin
      slot_r             <= pick_slot;
      new_r              <= !match;
      tseen_r[pick_slot] <= ts_r;
      if (!match) begin
        id_r[pick_slot] <= next_id_r;
      end
    end
    if (cmd.blend) begin
      case (field)
        FLD_PITCH: tpitch_r[slot_r] <= new_v;
        FLD_AMP:   tamp_r[slot_r]   <= new_v;
        FLD_CEN:   tcen_r[slot_r]   <= new_v;
        FLD_BW:    tbw_r[slot_r]    <= new_v;
        FLD_HARM:  tharm_r[slot_r]  <= new_v;
        FLD_COH:   tcoh_r[slot_r]   <= new_v;
        FLD_MOD:   tmod_r[slot_r]   <= new_v[7:0];
        default:   ;
      endcase
    end
    if (cmd.wght) begin
      wh_prod_r <= 33'(rd_harm) * 33'(coh_plus);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot_r  <= slot_ext[2:0];
      out_id_r    <= rd_id;
      out_new_r   <= new_r;
      out_pitch_r <= rd_pitch;
      out_amp_r   <= rd_amp;
      out_cen_r   <= rd_cen;
      out_bw_r    <= rd_bw;
      out_wh_r    <= (wh_q > 18'(UNIT_Q15)) ? UNIT_Q15 : wh_q[15:0];
      out_coh_r   <= (rd_coh > UNIT_Q15) ? UNIT_Q15 : rd_coh;
      out_mod_r   <= rd_mod;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_slot                 = out_slot_r;
  assign out_track_id             = out_id_r;
  assign out_is_new               = out_new_r;
  assign out_smoothed_pitch       = out_pitch_r;
  assign out_smoothed_amplitude   = out_amp_r;
  assign out_smoothed_centroid    = out_cen_r;
  assign out_smoothed_bandwidth   = out_bw_r;
  assign out_weighted_harmonicity = out_wh_r;
  assign out_smoothed_coherence   = out_coh_r;
  assign out_smoothed_modulation  = out_mod_r;

  a_slot_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.blend |-> act_r[slot_r])
    else $error("smoothing a slot that is not active");

  a_next_id: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick && !match |=> next_id_r == $past(next_id_r) + 8'd1)
    else $error("track id not advanced on a new slot");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && out_new_r == $past(new_r))
    else $error("result not presented after hand-off");

endmodule

### rtl/core/pitch_track_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_track_table_unit
// Table of pitch tracks with nearest-pitch association and EMA smoothing.
//
// Input channel (in_*): an observe item (action 0) is matched to the nearest
// active track within the window, or opens a slot, and gives one result on
// the out_* channel; an age item (action 1) retires idle tracks and gives
// no result. Items transfer when valid is high and stall is low.
// Steps: an observe item goes from transfer to result valid through a slot
// scan of one slot a cycle, slot choice, seven field updates through one
// shared multiplier, weighting and hand-off; an age item goes through an
// age pass over every slot. One item is worked on at a time, so the
// next item transfers once the previous one has finished, and an observe
// item finishes only once the output register is free.
// The result sits in an output register; while out_stall is high it holds,
// and the next finished result waits in the datapath until it is taken.
// Registers (APB, byte address 4*i): smoothing alpha, match window, stale
// limit. Reset empties the table, zeroes the id counter and restores the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pitch_track_table_unit
  import ptt_pkg::*;
#(
  parameter int TRACK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_timestamp_ms,
  input  logic [15:0] in_pitch,
  input  logic [15:0] in_amplitude,
  input  logic [15:0] in_centroid,
  input  logic [15:0] in_bandwidth,
  input  logic [15:0] in_harmonicity,
  input  logic [15:0] in_coherence,
  input  logic [7:0]  in_modulation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_track_id,
  output logic        out_is_new,
  output logic [15:0] out_smoothed_pitch,
  output logic [15:0] out_smoothed_amplitude,
  output logic [15:0] out_smoothed_centroid,
  output logic [15:0] out_smoothed_bandwidth,
  output logic [15:0] out_weighted_harmonicity,
  output logic [15:0] out_smoothed_coherence,
  output logic [7:0]  out_smoothed_modulation,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ptt_cmd_t    cmd;
  ptt_sts_t    sts;
  logic [8:0]  alpha_r;
  logic [15:0] window_r;
  logic [15:0] stale_r;
  ptt_reg_t    reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ptt_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RST;
      window_r <= WINDOW_RST;
      stale_r  <= STALE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ALPHA:  alpha_r  <= pwdata[8:0];
        REG_WINDOW: window_r <= pwdata[15:0];
        REG_STALE:  stale_r  <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ALPHA:  prdata = {23'd0, alpha_r};
      REG_WINDOW: prdata = {16'd0, window_r};
      REG_STALE:  prdata = {16'd0, stale_r};
      default:    prdata = '0;
    endcase
  end

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptt_dp #(
    .TRACK_SLOTS (TRACK_SLOTS)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .alpha                    (alpha_r),
    .window                   (window_r),
    .stale_limit              (stale_r),
    .in_timestamp_ms          (in_timestamp_ms),
    .in_pitch                 (in_pitch),
    .in_amplitude             (in_amplitude),
    .in_centroid              (in_centroid),
    .in_bandwidth             (in_bandwidth),
    .in_harmonicity           (in_harmonicity),
    .in_coherence             (in_coherence),
    .in_modulation            (in_modulation),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_slot                 (out_slot),
    .out_track_id             (out_track_id),
    .out_is_new               (out_is_new),
    .out_smoothed_pitch       (out_smoothed_pitch),
    .out_smoothed_amplitude   (out_smoothed_amplitude),
    .out_smoothed_centroid    (out_smoothed_centroid),
    .out_smoothed_bandwidth   (out_smoothed_bandwidth),
    .out_weighted_harmonicity (out_weighted_harmonicity),
    .out_smoothed_coherence   (out_smoothed_coherence),
    .out_smoothed_modulation  (out_smoothed_modulation)
  );

endmodule

### dv/pitch_track_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_track_table_unit_tb
// Self-checking bench for the pitch track table. A short directed table
// covers field extremes, pitch ties, modulation jumps, ageing, time running
// backwards, a full table and stalest-slot reuse. Random phases under
// several register settings then drive mostly voice-like candidate streams
// with some noise. Every result is checked against a bench track table mirror
// or a written-out directed row; input idles and output stalls at random.
// ----------------------------------------------------------------------------
module pitch_track_table_unit_tb
  import ptt_pkg::*;
();

  localparam int SLOTS = 8;
  localparam int VOICES = 6;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 275;
  localparam int DRAIN_CYCLES = 30;
  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_AGE = 1'b1;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic        action;
    logic [31:0] ts;
    logic [15:0] pitch;
    logic [15:0] amp;
    logic [15:0] cen;
    logic [15:0] bw;
    logic [15:0] harm;
    logic [15:0] coh;
    logic [7:0]  mod;
  } cand_t;

  typedef struct {
    logic [2:0]  slot;
    logic [7:0]  id;
    logic        is_new;
    logic [15:0] pitch;
    logic [15:0] amp;
    logic [15:0] cen;
    logic [15:0] bw;
    logic [15:0] wharm;
    logic [15:0] coh;
    logic [7:0]  mod;
  } track_out_t;

  typedef struct {
    cand_t      c;
    bit         typed;
    track_out_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [31:0] in_timestamp_ms = '0;
  logic [15:0] in_pitch = '0;
  logic [15:0] in_amplitude = '0;
  logic [15:0] in_centroid = '0;
  logic [15:0] in_bandwidth = '0;
  logic [15:0] in_harmonicity = '0;
  logic [15:0] in_coherence = '0;
  logic [7:0]  in_modulation = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_slot;
  logic [7:0]  out_track_id;
  logic        out_is_new;
  logic [15:0] out_smoothed_pitch;
  logic [15:0] out_smoothed_amplitude;
  logic [15:0] out_smoothed_centroid;
  logic [15:0] out_smoothed_bandwidth;
  logic [15:0] out_weighted_harmonicity;
  logic [15:0] out_smoothed_coherence;
  logic [7:0]  out_smoothed_modulation;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pitch_track_table_unit #(.TRACK_SLOTS(SLOTS)) i_dut (.*);

  always #5 clk = ~clk;

  // track table mirror
  bit          trk_live [SLOTS] = '{default: 1'b0};
  logic [7:0]  trk_id [SLOTS] = '{default: '0};
  logic [15:0] trk_pitch [SLOTS] = '{default: '0};
  logic [15:0] trk_amp [SLOTS] = '{default: '0};
  logic [15:0] trk_cen [SLOTS] = '{default: '0};
  logic [15:0] trk_bw [SLOTS] = '{default: '0};
  logic [15:0] trk_harm [SLOTS] = '{default: '0};
  logic [15:0] trk_coh [SLOTS] = '{default: '0};
  logic [7:0]  trk_mod [SLOTS] = '{default: '0};
  logic [31:0] trk_seen [SLOTS] = '{default: '0};
  logic [7:0]  id_next = '0;
  logic [8:0]  alpha_cfg = ALPHA_RST;
  logic [15:0] window_cfg = WINDOW_RST;
  logic [15:0] stale_cfg = STALE_RST;

  track_out_t  expected_tracks [$];
  dir_row_t    directed [$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  int unsigned sink_wait = 0;
  logic [31:0] clock_ms = 32'd1000;
  int          voice_pitch [VOICES];

  function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [15:0] ema(input int unsigned a, input int unsigned x,
                                      input int unsigned old);
    return 16'((a * x + (256 - a) * old + 128) >> 8);
  endfunction

  // applies one candidate to the mirror; returns 1 when a result follows
  function automatic bit associate_candidate(input cand_t c, output track_out_t r);
    int          best;
    int          s;
    int unsigned best_d;
    int unsigned d;
    int unsigned idle;
    int unsigned a;
    bit          fresh;
    longint unsigned wh;
    a = (alpha_cfg > ALPHA_ONE) ? 256 : alpha_cfg;
    r = '{default: '0};
    if (c.action == ACT_AGE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (trk_live[i]) begin
          idle = (c.ts >= trk_seen[i]) ? c.ts - trk_seen[i] : 0;
          if (idle > stale_cfg) trk_live[i] = 1'b0;
        end
      end
      return 1'b0;
    end
    best = -1;
    best_d = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (trk_live[i]) begin
        d = abs_diff(trk_pitch[i], c.pitch);
        if (best < 0 || d < best_d) begin
          best = i;
          best_d = d;
        end
      end
    end
    s = (best >= 0 && best_d < window_cfg) ? best : -1;
    fresh = (s < 0);
    if (fresh) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!trk_live[i]) s = i;
      if (s < 0) begin
        s = 0;
        for (int i = 1; i < SLOTS; i++) if (trk_seen[i] < trk_seen[s]) s = i;
      end
      trk_live[s] = 1'b1;
      trk_id[s] = id_next;
      id_next = id_next + 8'd1;
      trk_pitch[s] = c.pitch;
      trk_amp[s] = c.amp;
      trk_cen[s] = c.cen;
      trk_bw[s] = c.bw;
      trk_harm[s] = c.harm;
      trk_coh[s] = c.coh;
      trk_mod[s] = c.mod;
    end else begin
      trk_pitch[s] = ema(a, c.pitch, trk_pitch[s]);
      trk_amp[s] = ema(a, c.amp, trk_amp[s]);
      trk_cen[s] = ema(a, c.cen, trk_cen[s]);
      trk_bw[s] = ema(a, c.bw, trk_bw[s]);
      trk_harm[s] = ema(a, c.harm, trk_harm[s]);
      trk_coh[s] = ema(a, c.coh, trk_coh[s]);
      if (abs_diff(trk_mod[s], c.mod) > MOD_JUMP) trk_mod[s] = c.mod;
      else trk_mod[s] = 8'(ema(a, c.mod, trk_mod[s]));
    end
    trk_seen[s] = c.ts;
    wh = (64'(trk_harm[s]) * (64'(UNIT_Q15) + 64'(trk_coh[s])) + 64'd32768) >> 16;
    if (wh > UNIT_Q15) wh = UNIT_Q15;
    r.slot = 3'(s);
    r.id = trk_id[s];
    r.is_new = fresh;
    r.pitch = trk_pitch[s];
    r.amp = trk_amp[s];
    r.cen = trk_cen[s];
    r.bw = trk_bw[s];
    r.wharm = 16'(wh);
    r.coh = (trk_coh[s] > UNIT_Q15) ? UNIT_Q15 : trk_coh[s];
    r.mod = trk_mod[s];
    return 1'b1;
  endfunction

  function automatic cand_t cand(input logic act, input logic [31:0] ts,
                                 input logic [15:0] pitch, input logic [15:0] amp,
                                 input logic [15:0] cen, input logic [15:0] bw,
                                 input logic [15:0] harm, input logic [15:0] coh,
                                 input logic [7:0] mod);
    cand_t c;
    c = '{act, ts, pitch, amp, cen, bw, harm, coh, mod};
    return c;
  endfunction

  function automatic cand_t make_candidate();
    cand_t       c;
    int          v;
    int          p;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom_range(50, 1500);
    else clock_ms = clock_ms + $urandom_range(0, 15);
    c.action = ACT_OBSERVE;
    c.ts = clock_ms;
    c.pitch = 16'($urandom_range(0, 65535));
    c.amp = 16'($urandom_range(0, 65535));
    c.cen = 16'($urandom_range(0, 65535));
    c.bw = 16'($urandom_range(0, 65535));
    c.harm = 16'($urandom_range(0, 32768));
    c.coh = 16'($urandom_range(0, 32768));
    c.mod = 8'($urandom_range(0, 160));
    if (roll < 10) begin
      c.action = ACT_AGE;
      if ($urandom_range(0, 9) == 0) c.ts = $urandom;
    end else if (roll < 82) begin
      // candidate drifting around one of a few voices
      v = $urandom_range(0, VOICES - 1);
      if ($urandom_range(0, 19) == 0) voice_pitch[v] = $urandom_range(0, 65535);
      p = voice_pitch[v] + int'($urandom_range(0, 800)) - 400;
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      voice_pitch[v] = p;
      c.pitch = 16'(p);
    end else begin
      if ($urandom_range(0, 3) == 0) c.ts = $urandom;
      c.harm = 16'($urandom_range(0, 65535));
      c.coh = 16'($urandom_range(0, 65535));
      c.mod = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [31:0] cfg_mirror(input logic [1:0] idx);
    case (idx)
      REG_ALPHA:  return 32'(alpha_cfg);
      REG_WINDOW: return 32'(window_cfg);
      REG_STALE:  return 32'(stale_cfg);
      default:    return '0;
    endcase
  endfunction

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic compare_track(input track_out_t want, input track_out_t got);
    check_field("slot", want.slot, got.slot);
    check_field("track_id", want.id, got.id);
    check_field("is_new", want.is_new, got.is_new);
    check_field("smoothed_pitch", want.pitch, got.pitch);
    check_field("smoothed_amplitude", want.amp, got.amp);
    check_field("smoothed_centroid", want.cen, got.cen);
    check_field("smoothed_bandwidth", want.bw, got.bw);
    check_field("weighted_harmonicity", want.wharm, got.wharm);
    check_field("smoothed_coherence", want.coh, got.coh);
    check_field("smoothed_modulation", want.mod, got.mod);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ALPHA:  alpha_cfg = val[8:0];
      REG_WINDOW: window_cfg = val[15:0];
      REG_STALE:  stale_cfg = val[15:0];
      default:    ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("register readback", cfg_mirror(idx), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input cand_t c, input bit typed, input track_out_t want);
    int unsigned gap;
    track_out_t  pred;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= c.action;
    in_timestamp_ms <= c.ts;
    in_pitch <= c.pitch;
    in_amplitude <= c.amp;
    in_centroid <= c.cen;
    in_bandwidth <= c.bw;
    in_harmonicity <= c.harm;
    in_coherence <= c.coh;
    in_modulation <= c.mod;
    do @(posedge clk); while (in_stall);
    if (associate_candidate(c, pred)) expected_tracks.push_back(typed ? want : pred);
  endtask

  // wait out results and any age item still being worked on
  task automatic settle();
    while (expected_tracks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    track_out_t  want;
    track_out_t  got;
    int unsigned n;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_slot, out_track_id, out_is_new, out_smoothed_pitch,
              out_smoothed_amplitude, out_smoothed_centroid, out_smoothed_bandwidth,
              out_weighted_harmonicity, out_smoothed_coherence, out_smoothed_modulation};
      if (expected_tracks.size() == 0) begin
        $display("%0t ns: result with nothing expected, slot %0d id %0d",
                 $time, got.slot, got.id);
        errors++;
      end else begin
        want = expected_tracks.pop_front();
        compare_track(want, got);
      end
      n = draw_wait();
      sink_wait <= n;
      out_stall <= (n != 0);
    end else if (out_valid && out_stall) begin
      if (sink_wait <= 1) out_stall <= 1'b0;
      sink_wait <= sink_wait - 1;
    end
  end

  initial begin
    #5_000_000;
    $display("pitch_track_table_unit_tb: errors");
    $finish;
  end

  initial begin
    int unsigned alpha_set [PHASES];
    int unsigned window_set [PHASES];
    int unsigned stale_set [PHASES];
    track_out_t  none;
    alpha_set = '{128, 256, 0, 511, 0, 1};
    window_set = '{1280, 0, 65535, 800, 0, 2000};
    stale_set = '{300, 0, 65535, 50, 0, 150};
    none = '{default: '0};
    for (int v = 0; v < VOICES; v++) voice_pitch[v] = $urandom_range(800, 64000);

    directed.push_back('{cand(ACT_OBSERVE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{3'd0, 8'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                           16'd0, 8'd0}});
    directed.push_back('{cand(ACT_OBSERVE, 10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 8'hFF), 1'b1,
                         '{3'd1, 8'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           UNIT_Q15, UNIT_Q15, 8'hFF}});
    directed.push_back('{cand(ACT_OBSERVE, 20, 1000, 4000, 8000, 3000, 20000, 10000, 10),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 30, 2000, 100, 200, 300, 16384, 0, 0), 1'b1,
                         '{3'd2, 8'd2, 1'b1, 16'd2000, 16'd100, 16'd200, 16'd300,
                           16'd8192, 16'd0, 8'd0}});
    // equal distance to two tracks, the lower slot wins; modulation jump
    directed.push_back('{cand(ACT_OBSERVE, 40, 1250, 5000, 9000, 2500, 32768, 32768, 160),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 50, 1250, 6000, 9100, 2600, 30000, 30000, 150),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 60, 40000, 7000, 50000, 4000, 12000, 8000, 100),
                         1'b0, none});
    // modulation step of exactly 1.5 Hz still blends
    directed.push_back('{cand(ACT_OBSERVE, 70, 40100, 7100, 50100, 4100, 12100, 8100, 124),
                         1'b0, none});
    // idle equal to the limit survives, one more ms retires
    directed.push_back('{cand(ACT_AGE, 310, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back('{cand(ACT_AGE, 311, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    // time running backwards retires nothing
    directed.push_back('{cand(ACT_AGE, 5, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 320, 65535, 1, 1, 1, 1, 1, 1), 1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 330, 10000, 300, 400, 500, 600, 700, 20),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 340, 15000, 800, 900, 1000, 1100, 1200, 40),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 350, 20000, 1300, 1400, 1500, 1600, 1700, 60),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 360, 25000, 1800, 1900, 2000, 2100, 2200, 80),
                         1'b0, none});
    // full table, stalest slot reused
    directed.push_back('{cand(ACT_OBSERVE, 370, 50000, 2300, 2400, 2500, 2600, 2700, 90),
                         1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 370, 55000, 2800, 2900, 3000, 3100, 3200, 110),
                         1'b0, none});
    directed.push_back('{cand(ACT_AGE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, none});
    directed.push_back('{cand(ACT_OBSERVE, 32'hFFFF_FFFF, 123, 16'hFFFF, 0, 16'hFFFF,
                              32768, 32768, 160), 1'b0, none});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].c, directed[i].typed, directed[i].want);
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 4) begin
        alpha_set[ph] = $urandom_range(0, 511);
        window_set[ph] = $urandom_range(200, 3000);
        stale_set[ph] = $urandom_range(20, 500);
      end
      cfg_write(REG_ALPHA, alpha_set[ph]);
      cfg_write(REG_WINDOW, window_set[ph]);
      cfg_write(REG_STALE, stale_set[ph]);
      if (ph == 3) cfg_write(REG_SPARE, $urandom);
      for (int r = REG_ALPHA; r <= REG_STALE; r++) cfg_check(2'(r));
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(make_candidate(), 1'b0, none);
      in_valid <= 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("pitch_track_table_unit_tb: clean");
    end else begin
      $display("pitch_track_table_unit_tb: errors");
    end
    $finish;
  end

endmodule
